// ===== rtl/per_address_failure_counter_table_macros.svh =====
// ----------------------------------------------------------------------------
// per_address_failure_counter_table_macros
// assertion macros for the failure counter table rtl
// ----------------------------------------------------------------------------
`ifndef PER_ADDRESS_FAILURE_COUNTER_TABLE_MACROS_SVH
`define PER_ADDRESS_FAILURE_COUNTER_TABLE_MACROS_SVH

// same-cycle implication, checked out of reset
`define PAFCT_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("pafct assertion failed");

// next-cycle implication, checked out of reset
`define PAFCT_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("pafct assertion failed");

`endif

// ===== rtl/pafct_pkg.sv =====
// ----------------------------------------------------------------------------
// pafct_pkg
// types, constants and hash helper of the failure counter table
// ----------------------------------------------------------------------------
package pafct_pkg;

  localparam int BUCKETS = 64;
  localparam int WAYS    = 4;

  localparam int BKT_W = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
  localparam int WAY_W = (WAYS > 1) ? $clog2(WAYS) : 1;

  localparam logic [BKT_W-1:0] HASH_SEED = BKT_W'(5381);
  localparam logic [BKT_W-1:0] BKT_MASK  = BKT_W'(BUCKETS - 1);
  localparam logic [15:0]      HITS_MAX  = 16'hFFFF;
  localparam logic [15:0]      MAX_RETRY_RST = 16'd5;

  typedef enum logic [2:0] {
    STS_COUNTED   = 3'd0,
    STS_THRESHOLD = 3'd1,
    STS_ALREADY   = 3'd2,
    STS_IGNORED   = 3'd3,
    STS_FULL      = 3'd4,
    STS_MARKED    = 3'd5
  } status_e;

  typedef struct packed {
    logic [63:0] key_high;
    logic [63:0] key_low;
    logic [15:0] hits;
    logic        banned;
  } entry_t;

  typedef entry_t [WAYS-1:0] row_t;

  typedef struct packed {
    logic load;
    logic hash_hi;
    logic hash_lo;
    logic rd;
    logic lookup;
    logic update;
  } ctrl_cmd_t;

  typedef struct packed {
    logic out_full;
  } dp_status_t;

  // djb2 over eight bytes, msb first; only the low bucket bits are kept
  function automatic logic [BKT_W-1:0] hash_word(input logic [BKT_W-1:0] h_in,
                                                 input logic [63:0] w);
    logic [BKT_W-1:0] h;
    h = h_in;
    for (int i = 0; i < 8; i++) begin
      h = h + (h << 5) + BKT_W'(w[63-8*i -: 8]);
    end
    return h;
  endfunction

endpackage

// ===== rtl/pafct_ctrl.sv =====
// ----------------------------------------------------------------------------
// pafct_ctrl
// sequencer: hash, bucket read, compare, update
// ----------------------------------------------------------------------------
module pafct_ctrl import pafct_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  dp_status_t status_i,
  output ctrl_cmd_t  cmd_o
);

  typedef enum logic [5:0] {
    S_IDLE    = 6'b000001,
    S_HASH_HI = 6'b000010,
    S_HASH_LO = 6'b000100,
    S_READ    = 6'b001000,
    S_LOOKUP  = 6'b010000,
    S_UPDATE  = 6'b100000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_HASH_HI;
        end
      end
      S_HASH_HI: begin
        cmd_o.hash_hi = 1'b1;
        state_d       = S_HASH_LO;
      end
      S_HASH_LO: begin
        cmd_o.hash_lo = 1'b1;
        state_d       = S_READ;
      end
      S_READ: begin
        cmd_o.rd = 1'b1;
        state_d  = S_LOOKUP;
      end
      S_LOOKUP: begin
        cmd_o.lookup = 1'b1;
        state_d      = S_UPDATE;
      end
      S_UPDATE: begin
        // hold until the previous result has left the output register
        if (!status_i.out_full) begin
          cmd_o.update = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign in_ready_o = (state_q == S_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== rtl/pafct_dp.sv =====
// ----------------------------------------------------------------------------
// pafct_dp
// key capture, hash, bucket store, way compare, entry update and result
// ----------------------------------------------------------------------------
`include "per_address_failure_counter_table_macros.svh"

module pafct_dp import pafct_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  ctrl_cmd_t   cmd_i,
  output dp_status_t  status_o,
  input  logic        mode_i,
  input  logic [63:0] key_high_i,
  input  logic [63:0] key_low_i,
  input  logic        ignored_i,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  status_code_o,
  output logic [15:0] fail_count_o
);

  logic [15:0]       max_retry_q;
  logic              mode_q, ign_q;
  logic [63:0]       key_high_q, key_low_q;
  logic [BKT_W-1:0]  hash_q;
  logic [BKT_W-1:0]  bucket;

  row_t              mem_q [BUCKETS];
  logic [BUCKETS-1:0][WAYS-1:0] valid_q;

  row_t              rd_row_q;
  logic [WAYS-1:0]   rd_valid_q;

  logic [WAYS-1:0]   match, free;
  logic              any_match, any_free;
  logic [WAY_W-1:0]  match_way, free_way;

  logic              found_q, full_q;
  logic [WAY_W-1:0]  way_q;

  entry_t            cur, nxt;
  row_t              wr_row;
  logic              do_write;
  status_e           sts;
  logic [15:0]       res_hits;

  logic              out_valid_q;
  status_e           out_sts_q;
  logic [15:0]       out_hits_q;

  assign bucket = hash_q & BKT_MASK;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_retry_q <= MAX_RETRY_RST;
    end else if (cfg_we_i) begin
      max_retry_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      mode_q     <= mode_i;
      ign_q      <= ignored_i;
      key_high_q <= key_high_i;
      key_low_q  <= key_low_i;
    end
    if (cmd_i.hash_hi) begin
      hash_q <= hash_word(HASH_SEED, key_high_q);
    end
    if (cmd_i.hash_lo) begin
      hash_q <= hash_word(hash_q, key_low_q);
    end
  end

  // bucket store, one row per bucket
  always_ff @(posedge clk_i) begin
    if (cmd_i.rd) begin
      rd_row_q <= mem_q[bucket];
    end
    if (do_write) begin
      mem_q[bucket] <= wr_row;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (do_write) begin
      valid_q[bucket][way_q] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd) begin
      rd_valid_q <= valid_q[bucket];
    end
  end

  always_comb begin
    match_way = '0;
    free_way  = '0;
    for (int w = 0; w < WAYS; w++) begin
      match[w] = rd_valid_q[w] && (rd_row_q[w].key_high == key_high_q)
                 && (rd_row_q[w].key_low == key_low_q);
      free[w]  = !rd_valid_q[w];
    end
    for (int w = WAYS - 1; w >= 0; w--) begin
      if (match[w]) match_way = WAY_W'(w);
      if (free[w])  free_way  = WAY_W'(w);
    end
    any_match = |match;
    any_free  = |free;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.lookup) begin
      found_q <= any_match;
      full_q  <= !any_match && !any_free;
      way_q   <= any_match ? match_way : free_way;
    end
  end

  always_comb begin
    if (found_q) begin
      cur = rd_row_q[way_q];
    end else begin
      cur.key_high = key_high_q;
      cur.key_low  = key_low_q;
      cur.hits     = '0;
      cur.banned   = 1'b0;
    end
    nxt      = cur;
    do_write = 1'b0;
    sts      = STS_COUNTED;
    res_hits = '0;
    if (ign_q) begin
      sts = STS_IGNORED;
    end else if (full_q) begin
      sts = STS_FULL;
    end else if (mode_q) begin
      nxt.banned = 1'b1;
      do_write   = cmd_i.update;
      sts        = STS_MARKED;
      res_hits   = cur.hits;
    end else if (cur.banned) begin
      // a fresh entry is never banned, so nothing new to store here
      sts      = STS_ALREADY;
      res_hits = cur.hits;
    end else begin
      nxt.hits = (cur.hits == HITS_MAX) ? cur.hits : cur.hits + 16'd1;
      do_write = cmd_i.update;
      sts      = (nxt.hits >= max_retry_q) ? STS_THRESHOLD : STS_COUNTED;
      res_hits = nxt.hits;
    end
    wr_row        = rd_row_q;
    wr_row[way_q] = nxt;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.update) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.update) begin
      out_sts_q  <= sts;
      out_hits_q <= res_hits;
    end
  end

  assign status_o.out_full = out_valid_q;
  assign out_valid_o       = out_valid_q;
  assign status_code_o     = out_sts_q;
  assign fail_count_o      = out_hits_q;

  `PAFCT_ASSERT_IMP(a_update_out_free, cmd_i.update, !out_valid_q)
  `PAFCT_ASSERT_NXT(a_update_shows_result, cmd_i.update, out_valid_q)
  `PAFCT_ASSERT_IMP(a_single_match, cmd_i.lookup, $onehot0(match))

endmodule

// ===== rtl/per_address_failure_counter_table.sv =====
// ----------------------------------------------------------------------------
// per_address_failure_counter_table
// Counts failure events per 128-bit source address in a hashed table of
// 64 buckets by 4 ways. An item is taken only while the sequencer is idle
// and passes in order through djb2 hashing of the high and then the low key
// word at eight bytes each, a bucket row read, a way compare and a
// read-modify-write of the row before its result is registered on the output.
// The next item is taken only once the sequencer is back in idle, and the update
// waits while an earlier result still sits unread in the output register.
// The table is empty straight after reset; max_retry resets to 5.
// ----------------------------------------------------------------------------
module per_address_failure_counter_table import pafct_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [127:0] s_axis_tdata,   // key_high [63:0], key_low [127:64]
  input  logic [1:0]   s_axis_tuser,   // mode [0], ignored [1]
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [15:0]  m_axis_tdata,   // fail_count [15:0]
  output logic [2:0]   m_axis_tuser,   // status [2:0]
  input  logic         cfg_we_i,
  input  logic [15:0]  cfg_wdata_i
);

  ctrl_cmd_t  cmd;
  dp_status_t dp_status;

  pafct_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .status_i   (dp_status),
    .cmd_o      (cmd)
  );

  pafct_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .status_o      (dp_status),
    .mode_i        (s_axis_tuser[0]),
    .key_high_i    (s_axis_tdata[63:0]),
    .key_low_i     (s_axis_tdata[127:64]),
    .ignored_i     (s_axis_tuser[1]),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .out_valid_o   (m_axis_tvalid),
    .out_ready_i   (m_axis_tready),
    .status_code_o (m_axis_tuser),
    .fail_count_o  (m_axis_tdata)
  );

endmodule
